### rtl/bfu_pkg.sv
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared types, codes and helpers for the flocking particle update block.
// ----------------------------------------------------------------------------
package bfu_pkg;

    localparam int MAX_PARTICLES_DEF = 64;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [1:0] CFG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CDIV  = 2'd1;
    localparam logic [1:0] CFG_SDIST = 2'd2;
    localparam logic [1:0] CFG_ADIV  = 2'd3;

    localparam logic [6:0]  COUNT_RST = 7'd2;
    localparam logic [15:0] CDIV_RST  = 16'd100;
    localparam logic [22:0] SDIST_RST = 23'd2560;
    localparam logic [15:0] ADIV_RST  = 16'd8;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         index;
        logic signed [23:0] pos_x_in;
        logic signed [23:0] pos_y_in;
        logic signed [23:0] vel_x_in;
        logic signed [23:0] vel_y_in;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         index_out;
        logic signed [23:0] pos_x_out;
        logic signed [23:0] pos_y_out;
        logic signed [23:0] vel_x_out;
        logic signed [23:0] vel_y_out;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [22:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
    } t_particle;

    // Returns the saturation flag above the clamped 24-bit value.
    function automatic logic [24:0] sat24(input logic signed [63:0] v);
        logic [24:0] res;
        if (v > 64'sd8388607) begin
            res = {1'b1, 24'h7FFFFF};
        end else if (v < -64'sd8388608) begin
            res = {1'b1, 24'h800000};
        end else begin
            res = {1'b0, v[23:0]};
        end
        return res;
    endfunction

endpackage

### rtl/bfu_ifs.sv
// ----------------------------------------------------------------------------
// bfu interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface bfu_in_if;
    logic              valid;
    logic              ready;
    bfu_pkg::t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface bfu_out_if;
    logic               valid;
    logic               ready;
    bfu_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface bfu_cfg_if;
    logic               valid;
    logic               ready;
    bfu_pkg::t_cfg_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/bfu_ram.sv
// ----------------------------------------------------------------------------
// bfu_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bfu_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/bfu_div.sv
// ----------------------------------------------------------------------------
// bfu_div
// Restoring divider, one quotient bit per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
module bfu_div #(
    parameter int NW = 32,
    parameter int DW = 23
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NW-1:0]       i_num_mag,
    input  logic                i_neg,
    input  logic [DW-1:0]       i_den,
    output logic                o_done,
    output logic signed [NW:0]  o_quot
);
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic            r_neg;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DW:0]     w_trial;
    logic            w_fit;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num_mag;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_neg;
                r_cnt  <= CNTW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_fit ? DW'(w_trial - {1'b0, r_den}) : DW'(w_trial);
                r_num  <= {r_num[NW-2:0], w_fit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
endmodule

### rtl/boids_flock_update.sv
// ----------------------------------------------------------------------------
// boids_flock_update
// Particle table with write, read and in-place flocking update items.
// ----------------------------------------------------------------------------
// A write or out-of-range item goes from S_IDLE straight to S_EMIT, a read
// through S_RD first, and an update through S_SELF, a sweep over the table's
// read port, then S_PREP and S_DIV once for each of four divisions on the shared
// one-bit-per-cycle divider, then S_VEL, S_POS and S_EMIT, which waits while the
// result output is stalled. One item is in flight at a time.
// Reset clears control state and the configuration registers; table entries hold garbage until written.
module boids_flock_update #(
    parameter int MAX_PARTICLES = bfu_pkg::MAX_PARTICLES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfu_in_if.sink    i_item,
    bfu_out_if.source o_res,
    bfu_cfg_if.sink   i_cfg
);
    localparam int AW   = $clog2(MAX_PARTICLES);
    localparam int CW   = $clog2(MAX_PARTICLES + 1);
    localparam int SW   = 24 + AW + 1;
    localparam int NW   = SW + 1;
    localparam int DW   = CW + 16;
    localparam int SEPW = 25 + AW;
    localparam int TW   = NW + 3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SELF, S_SWEEP, S_PREP, S_DIV, S_VEL, S_POS, S_EMIT
    } t_state;

    t_state              r_state;
    logic [6:0]          r_count;
    logic [15:0]         r_cdiv;
    logic [22:0]         r_sdist;
    logic [15:0]         r_adiv;
    logic [5:0]          r_idx;
    bfu_pkg::t_particle  r_own;
    bfu_pkg::t_out_item  r_res;
    bfu_pkg::t_out_item  r_out;
    logic                r_out_valid;
    logic [45:0]         r_d2;
    logic [CW-1:0]       r_j;
    logic                r_va, r_vb, r_vc;
    logic signed [SW-1:0] r_spx, r_spy, r_svx, r_svy;
    logic signed [24:0]  r_dxa, r_dya, r_dxb, r_dyb;
    logic [49:0]         r_sqx, r_sqy;
    logic signed [SEPW-1:0] r_sepx, r_sepy;
    logic [1:0]          r_k;
    logic [NW-1:0]       r_dmag;
    logic                r_dneg;
    logic [DW-1:0]       r_den;
    logic                r_start;
    logic signed [NW:0]  r_q [4];
    logic signed [23:0]  r_nvx, r_nvy;
    logic                r_sat;

    logic [CW-1:0]       w_n, w_m;
    logic                w_acc, w_range, w_out_free, w_issue;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    bfu_pkg::t_particle  ram_wdata, ram_rdata;
    logic [15:0]         w_cd, w_ad, w_div;
    logic signed [SW-1:0] w_sum;
    logic signed [23:0]  w_ownsel;
    logic signed [CW+24:0] w_mo;
    logic signed [NW-1:0] w_num;
    logic [DW-1:0]       w_den;
    logic                div_done;
    logic signed [NW:0]  div_quot;
    logic [50:0]         w_dist2;
    logic signed [TW-1:0] w_totx, w_toty;
    logic [24:0]         w_satvx, w_satvy, w_satpx, w_satpy;
    logic signed [24:0]  w_sposx, w_sposy;

    always_comb begin
        if (r_count < 7'd2) begin
            w_n = CW'(2);
        end else if ({25'd0, r_count} > 32'(MAX_PARTICLES)) begin
            w_n = CW'(MAX_PARTICLES);
        end else begin
            w_n = CW'(r_count);
        end
    end
    assign w_m = w_n - 1'b1;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    assign w_acc      = i_item.valid && i_item.ready;
    assign w_range    = ({{CW{1'b0}}, i_item.data.index} < {6'd0, w_n});
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_issue    = (r_state == S_SWEEP) && (r_j < w_n);

    assign w_cd = (r_cdiv == 16'd0) ? 16'd1 : r_cdiv;
    assign w_ad = (r_adiv == 16'd0) ? 16'd1 : r_adiv;

    always_comb begin
        case (r_k)
            2'd0: begin
                w_sum = r_spx; w_ownsel = r_own.px; w_div = w_cd;
            end
            2'd1: begin
                w_sum = r_spy; w_ownsel = r_own.py; w_div = w_cd;
            end
            2'd2: begin
                w_sum = r_svx; w_ownsel = r_own.vx; w_div = w_ad;
            end
            default: begin
                w_sum = r_svy; w_ownsel = r_own.vy; w_div = w_ad;
            end
        endcase
    end
    assign w_mo  = $signed({1'b0, w_m}) * w_ownsel;
    assign w_num = NW'(w_sum) - NW'(w_mo);
    assign w_den = w_m * w_div;

    assign w_dist2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    assign w_totx = TW'(r_own.vx) + TW'(r_q[0]) + TW'(r_sepx) + TW'(r_q[2]);
    assign w_toty = TW'(r_own.vy) + TW'(r_q[1]) + TW'(r_sepy) + TW'(r_q[3]);
    assign w_satvx = bfu_pkg::sat24(64'(w_totx));
    assign w_satvy = bfu_pkg::sat24(64'(w_toty));
    assign w_sposx = 25'(r_own.px) + 25'(r_nvx);
    assign w_sposy = 25'(r_own.py) + 25'(r_nvy);
    assign w_satpx = bfu_pkg::sat24(64'(w_sposx));
    assign w_satpy = bfu_pkg::sat24(64'(w_sposy));

    always_comb begin
        ram_re    = w_issue || (w_acc && w_range && i_item.data.mode != bfu_pkg::MODE_WRITE);
        ram_raddr = (r_state == S_SWEEP) ? r_j[AW-1:0] : AW'(i_item.data.index);
        if (r_state == S_POS) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_idx);
            ram_wdata = {w_satpx[23:0], w_satpy[23:0], r_nvx, r_nvy};
        end else begin
            ram_we    = w_acc && w_range && i_item.data.mode == bfu_pkg::MODE_WRITE;
            ram_waddr = AW'(i_item.data.index);
            ram_wdata = {i_item.data.pos_x_in, i_item.data.pos_y_in,
                         i_item.data.vel_x_in, i_item.data.vel_y_in};
        end
    end

    bfu_ram #(
        .WIDTH($bits(bfu_pkg::t_particle)),
        .DEPTH(MAX_PARTICLES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    bfu_div #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_num_mag(r_dmag),
        .i_neg    (r_dneg),
        .i_den    (r_den),
        .o_done   (div_done),
        .o_quot   (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= bfu_pkg::COUNT_RST;
            r_cdiv      <= bfu_pkg::CDIV_RST;
            r_sdist     <= bfu_pkg::SDIST_RST;
            r_adiv      <= bfu_pkg::ADIV_RST;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_vc        <= 1'b0;
            r_start     <= 1'b0;
            r_k         <= '0;
            r_j         <= '0;
        end else begin
            r_start <= (r_state == S_PREP);
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.data.index)
                    bfu_pkg::CFG_COUNT: r_count <= i_cfg.data.value[6:0];
                    bfu_pkg::CFG_CDIV:  r_cdiv  <= i_cfg.data.value[15:0];
                    bfu_pkg::CFG_SDIST: r_sdist <= i_cfg.data.value;
                    bfu_pkg::CFG_ADIV:  r_adiv  <= i_cfg.data.value[15:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_idx <= i_item.data.index;
                        if (!w_range) begin
                            r_res   <= '{index_out: i_item.data.index, pos_x_out: '0,
                                         pos_y_out: '0, vel_x_out: '0, vel_y_out: '0,
                                         status: bfu_pkg::ST_RANGE};
                            r_state <= S_EMIT;
                        end else if (i_item.data.mode == bfu_pkg::MODE_WRITE) begin
                            r_res   <= '{index_out: i_item.data.index,
                                         pos_x_out: i_item.data.pos_x_in,
                                         pos_y_out: i_item.data.pos_y_in,
                                         vel_x_out: i_item.data.vel_x_in,
                                         vel_y_out: i_item.data.vel_y_in,
                                         status: bfu_pkg::ST_OK};
                            r_state <= S_EMIT;
                        end else if (i_item.data.mode == bfu_pkg::MODE_UPDATE) begin
                            r_state <= S_SELF;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_res   <= '{index_out: r_idx, pos_x_out: ram_rdata.px,
                                 pos_y_out: ram_rdata.py, vel_x_out: ram_rdata.vx,
                                 vel_y_out: ram_rdata.vy, status: bfu_pkg::ST_OK};
                    r_state <= S_EMIT;
                end
                S_SELF: begin
                    r_own   <= ram_rdata;
                    r_d2    <= r_sdist * r_sdist;
                    r_spx   <= '0;
                    r_spy   <= '0;
                    r_svx   <= '0;
                    r_svy   <= '0;
                    r_sepx  <= '0;
                    r_sepy  <= '0;
                    r_j     <= '0;
                    r_va    <= 1'b0;
                    r_vb    <= 1'b0;
                    r_vc    <= 1'b0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (w_issue) begin
                        r_j <= r_j + 1'b1;
                    end
                    r_va <= w_issue && (r_j[AW-1:0] != AW'(r_idx));
                    if (r_va) begin
                        r_spx <= r_spx + SW'(ram_rdata.px);
                        r_spy <= r_spy + SW'(ram_rdata.py);
                        r_svx <= r_svx + SW'(ram_rdata.vx);
                        r_svy <= r_svy + SW'(ram_rdata.vy);
                    end
                    r_dxa <= 25'(ram_rdata.px) - 25'(r_own.px);
                    r_dya <= 25'(ram_rdata.py) - 25'(r_own.py);
                    r_vb  <= r_va;
                    r_sqx <= 50'(r_dxa * r_dxa);
                    r_sqy <= 50'(r_dya * r_dya);
                    r_dxb <= r_dxa;
                    r_dyb <= r_dya;
                    r_vc  <= r_vb;
                    if (r_vc && (w_dist2 < 51'(r_d2))) begin
                        r_sepx <= r_sepx - SEPW'(r_dxb);
                        r_sepy <= r_sepy - SEPW'(r_dyb);
                    end
                    if (!w_issue && !r_va && !r_vb && !r_vc) begin
                        r_k     <= '0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_dneg  <= w_num[NW-1];
                    r_dmag  <= w_num[NW-1] ? NW'(-w_num) : NW'(w_num);
                    r_den   <= w_den;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_q[r_k] <= div_quot;
                        if (r_k == 2'd3) begin
                            r_state <= S_VEL;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_VEL: begin
                    r_nvx   <= w_satvx[23:0];
                    r_nvy   <= w_satvy[23:0];
                    r_sat   <= w_satvx[24] || w_satvy[24];
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_res   <= '{index_out: r_idx, pos_x_out: w_satpx[23:0],
                                 pos_y_out: w_satpy[23:0], vel_x_out: r_nvx,
                                 vel_y_out: r_nvy,
                                 status: (r_sat || w_satpx[24] || w_satpy[24]) ?
                                         bfu_pkg::ST_SAT : bfu_pkg::ST_OK};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/bfu_chk.sv
// ----------------------------------------------------------------------------
// bfu_chk
// Port-level checks for the flocking particle update block.
// ----------------------------------------------------------------------------
module bfu_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input bfu_pkg::t_out_item i_out_data
);
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !(i_in_valid && i_in_ready))
        else $error("Two items accepted on consecutive cycles.");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.status == bfu_pkg::ST_RANGE) |->
        (i_out_data.pos_x_out == '0 && i_out_data.pos_y_out == '0 &&
         i_out_data.vel_x_out == '0 && i_out_data.vel_y_out == '0))
        else $error("Out-of-range result carries nonzero values.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("Stalled result changed or dropped.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");
endmodule

bind boids_flock_update bfu_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_item.valid),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_out_data (o_res.data)
);
